[src/qrs_pkg.sv]
package qrs_pkg;

    localparam int KIND_W = 3;
    localparam int ROOT_W = 33;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_DOUBLE = 3'd1,
        KIND_TWO    = 3'd2,
        KIND_LINEAR = 3'd3,
        KIND_CONTRA = 3'd4
    } kind_t;

    localparam logic [ROOT_W-1:0] ROOT_POS_LIM = 33'h0_FFFF_FFFF;
    localparam logic [ROOT_W-1:0] ROOT_NEG_LIM = 33'h1_0000_0000;

endpackage

[src/qrs_front.sv]
module qrs_front #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   coef_a,
    input  logic signed [W-1:0]   coef_b,
    input  logic signed [W-1:0]   coef_c,
    output logic                  out_valid,
    output logic signed [W-1:0]   out_a,
    output logic signed [W-1:0]   out_b,
    output logic signed [W-1:0]   out_c,
    output qrs_pkg::kind_t        out_kind,
    output logic [2*W+1:0]        out_rad
);
    import qrs_pkg::*;

    logic                  v1_reg;
    logic signed [W-1:0]   a1_reg;
    logic signed [W-1:0]   b1_reg;
    logic signed [W-1:0]   c1_reg;
    logic signed [2*W-1:0] bsq_reg;
    logic signed [2*W-1:0] ac_reg;

    logic                  v2_reg;
    logic signed [W-1:0]   a2_reg;
    logic signed [W-1:0]   b2_reg;
    logic signed [W-1:0]   c2_reg;
    kind_t                 kind_reg;
    logic [2*W+1:0]        rad_reg;

    logic signed [2*W+1:0] delta;
    kind_t                 kind_next;
    logic [2*W+1:0]        rad_next;

    assign delta = (2*W+2)'(bsq_reg) - ((2*W+2)'(ac_reg) <<< 2);

    always_comb
    begin
        rad_next = '0;
        if (a1_reg == '0)
        begin
            kind_next = (b1_reg == '0) ? KIND_CONTRA : KIND_LINEAR;
        end
        else if (delta < 0)
        begin
            kind_next = KIND_NONE;
        end
        else
        begin
            kind_next = (delta == '0) ? KIND_DOUBLE : KIND_TWO;
            rad_next  = delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            c1_reg   <= coef_c;
            bsq_reg  <= coef_b * coef_b;
            ac_reg   <= coef_a * coef_c;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            kind_reg <= kind_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_a     = a2_reg;
    assign out_b     = b2_reg;
    assign out_c     = c2_reg;
    assign out_kind  = kind_reg;
    assign out_rad   = rad_reg;

endmodule

[src/qrs_sqrt.sv]
module qrs_sqrt #(
    parameter int SW = 17,
    parameter int TW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [2*SW-1:0] rad,
    input  logic [TW-1:0]   in_tag,
    output logic            out_valid,
    output logic [SW-1:0]   root,
    output logic [TW-1:0]   out_tag
);
    localparam int RW = 2 * SW;

    logic [SW:0]    rem_reg  [SW];
    logic [SW-1:0]  root_reg [SW];
    logic [RW-1:0]  x_reg    [SW];
    logic [TW-1:0]  tag_reg  [SW];
    logic           v_reg    [SW];

    for (genvar k = 0; k < SW; k++)
    begin : g_step
        logic [SW:0]   rem_in;
        logic [SW-1:0] root_in;
        logic [RW-1:0] x_in;
        logic [TW-1:0] tag_in;
        logic          v_in;
        logic [SW+2:0] rem_sh;
        logic [SW+2:0] trial;
        logic          fit;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = rad;
            assign tag_in  = in_tag;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign rem_sh = {rem_in, x_in[RW-1:RW-2]};
        assign trial  = (SW+3)'({root_in, 2'b01});
        assign fit    = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= fit ? (SW+1)'(rem_sh - trial) : rem_sh[SW:0];
                root_reg[k] <= {root_in[SW-2:0], fit};
                x_reg[k]    <= x_in << 2;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign out_tag   = tag_reg[SW-1];

endmodule

[src/qrs_div.sv]
module qrs_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int TW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] out_tag
);
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [DW-1:0] den_reg [NW];
    logic [TW-1:0] tag_reg [NW];
    logic          v_reg   [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [DW-1:0] rem_in;
        logic [NW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [TW-1:0] tag_in;
        logic          v_in;
        logic [DW:0]   trial;
        logic          fit;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = num;
            assign d_in   = den;
            assign tag_in = in_tag;
            assign v_in   = in_valid;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        assign trial = {rem_in, q_in[NW-1]};
        assign fit   = trial >= {1'b0, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= fit ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
                q_reg[k]   <= {q_in[NW-2:0], fit};
                den_reg[k] <= d_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = q_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];

endmodule

[src/quadratic_root_solver.sv]
// channel  | handshake           | payload
// input    | in_valid / in_stall  | coef_a, coef_b, coef_c
// output   | out_valid / out_stall| root_kind, first_root, second_root
// One beat enters per cycle while in_stall is low. The square root yields one bit per
// stage, and the two dividers are restoring dividers.
// Reset clears only the valid bits of every stage.
// The whole pipeline holds while a result beat waits under out_stall; in_stall
// follows that condition.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qrs_pkg::kind_t                root_kind,
    output logic signed [qrs_pkg::ROOT_W-1:0] first_root,
    output logic signed [qrs_pkg::ROOT_W-1:0] second_root
);
    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int SW  = W + 1;
    localparam int NMW = W + 2;
    localparam int NW  = NMW + FRAC_BITS;
    localparam int DW  = W + 1;
    localparam int STW = KIND_W + 3 * W;
    localparam int QX  = ((NW > ROOT_W) ? NW : ROOT_W) + 1;

    logic adv;

    logic                fr_valid;
    logic signed [W-1:0] fr_a;
    logic signed [W-1:0] fr_b;
    logic signed [W-1:0] fr_c;
    kind_t               fr_kind;
    logic [2*W+1:0]      fr_rad;

    logic                sq_valid;
    logic [SW-1:0]       sq_root;
    logic [STW-1:0]      sq_tag;
    kind_t               sq_kind;
    logic signed [W-1:0] sq_a;
    logic signed [W-1:0] sq_b;
    logic signed [W-1:0] sq_c;

    logic signed [W+2:0] n1;
    logic signed [W+2:0] n2;
    logic signed [W+1:0] dn;
    logic [NMW-1:0]      n1_mag;
    logic [NMW-1:0]      n2_mag;
    logic [DW-1:0]       dn_mag;

    logic                nm_valid_reg;
    kind_t               nm_kind_reg;
    logic [NW-1:0]       n1_reg;
    logic [NW-1:0]       n2_reg;
    logic [DW-1:0]       dn_reg;
    logic                s1_reg;
    logic                s2_reg;

    logic                d1_valid;
    logic [NW-1:0]       q1;
    logic [KIND_W:0]     d1_tag;
    logic                d2_valid;
    logic [NW-1:0]       q2;
    logic                d2_tag;

    kind_t               d_kind;
    logic [ROOT_W-1:0]   r1_next;
    logic [ROOT_W-1:0]   r2_next;

    logic                out_valid_reg;
    kind_t               kind_reg;
    logic [ROOT_W-1:0]   r1_reg;
    logic [ROOT_W-1:0]   r2_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    qrs_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .out_valid (fr_valid),
        .out_a     (fr_a),
        .out_b     (fr_b),
        .out_c     (fr_c),
        .out_kind  (fr_kind),
        .out_rad   (fr_rad)
    );

    qrs_sqrt #(.SW(SW), .TW(STW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .rad       (fr_rad),
        .in_tag    ({fr_kind, fr_a, fr_b, fr_c}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    assign sq_kind = kind_t'(sq_tag[STW-1 -: KIND_W]);
    assign sq_a    = sq_tag[3*W-1 -: W];
    assign sq_b    = sq_tag[2*W-1 -: W];
    assign sq_c    = sq_tag[W-1:0];

    always_comb
    begin
        if (sq_kind == KIND_LINEAR)
        begin
            n1 = -(W+3)'(sq_c);
            n2 = n1;
            dn = (W+2)'(sq_b);
        end
        else
        begin
            n1 = -(W+3)'(sq_b) - $signed((W+3)'(sq_root));
            n2 = -(W+3)'(sq_b) + $signed((W+3)'(sq_root));
            if (sq_kind == KIND_DOUBLE || sq_kind == KIND_TWO)
                dn = (W+2)'(sq_a) <<< 1;
            else
                dn = (W+2)'(1);
        end
        n1_mag = n1[W+2] ? NMW'(-n1) : NMW'(n1);
        n2_mag = n2[W+2] ? NMW'(-n2) : NMW'(n2);
        dn_mag = dn[W+1] ? DW'(-dn) : DW'(dn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_valid_reg <= 1'b0;
        else if (adv)
            nm_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nm_kind_reg <= sq_kind;
            n1_reg      <= NW'(n1_mag) << FRAC_BITS;
            n2_reg      <= NW'(n2_mag) << FRAC_BITS;
            dn_reg      <= dn_mag;
            s1_reg      <= n1[W+2] ^ dn[W+1];
            s2_reg      <= n2[W+2] ^ dn[W+1];
        end
    end

    qrs_div #(.NW(NW), .DW(DW), .TW(KIND_W + 1)) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nm_valid_reg),
        .num       (n1_reg),
        .den       (dn_reg),
        .in_tag    ({nm_kind_reg, s1_reg}),
        .out_valid (d1_valid),
        .quo       (q1),
        .out_tag   (d1_tag)
    );

    qrs_div #(.NW(NW), .DW(DW), .TW(1)) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nm_valid_reg),
        .num       (n2_reg),
        .den       (dn_reg),
        .in_tag    (s2_reg),
        .out_valid (d2_valid),
        .quo       (q2),
        .out_tag   (d2_tag)
    );

    assign d_kind = kind_t'(d1_tag[KIND_W:1]);

    function automatic logic [ROOT_W-1:0] sat_root(input logic [NW-1:0] q, input logic neg);
        logic [QX-1:0] qe;
        qe = QX'(q);
        if (!neg)
            sat_root = (qe > QX'(ROOT_POS_LIM)) ? ROOT_POS_LIM : qe[ROOT_W-1:0];
        else
            sat_root = (qe > QX'(ROOT_NEG_LIM)) ? ROOT_NEG_LIM : -qe[ROOT_W-1:0];
    endfunction

    always_comb
    begin
        if (d_kind == KIND_NONE || d_kind == KIND_CONTRA)
        begin
            r1_next = '0;
            r2_next = '0;
        end
        else
        begin
            r1_next = sat_root(q1, d1_tag[0]);
            r2_next = sat_root(q2, d2_tag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg <= d_kind;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_kind   = kind_reg;
    assign first_root  = r1_reg;
    assign second_root = r2_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid == d2_valid)
        else $error("dividers out of step");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_NONE || root_kind == KIND_CONTRA)
        |-> first_root == '0 && second_root == '0)
        else $error("root given where none exists");

    a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_LINEAR || root_kind == KIND_DOUBLE)
        |-> first_root == second_root)
        else $error("single root differs between outputs");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_root) && $stable(second_root))
        else $error("held result changed");

endmodule
